>>> rtl/core/iira_pkg.sv
// Shared codes for the indexed insert/remove array: request kinds, status codes, cell commands.
package iira_pkg;

   localparam int DefaultCapacity  = 16;
   localparam int DefaultDataWidth = 32;

   typedef enum logic [2:0] {
      KIND_PUSH   = 3'd0,
      KIND_POP    = 3'd1,
      KIND_INSERT = 3'd2,
      KIND_REMOVE = 3'd3,
      KIND_GET    = 3'd4,
      KIND_SET    = 3'd5,
      KIND_CLEAR  = 3'd6
   } kind_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_RANGE = 2'd2,
      ST_EMPTY = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      CMD_NONE,
      CMD_WRITE,
      CMD_INSERT,
      CMD_REMOVE,
      CMD_CLEAR
   } cell_cmd_type;

endpackage

>>> rtl/core/iira_cell.sv
// One storage cell of the array: holds a word and takes it from a neighbor on shifts.
module iira_cell #(
   parameter int DATA_WIDTH = 32,
   parameter int CNT_W      = 5,
   parameter int IDX        = 0
) (
   input  logic                   clock,
   input  logic                   reset,
   input  iira_pkg::cell_cmd_type cmd,
   input  logic [CNT_W-1:0]       index,
   input  logic [CNT_W-1:0]       limit,
   input  logic [DATA_WIDTH-1:0]  word,
   input  logic [DATA_WIDTH-1:0]  left_word,
   input  logic [DATA_WIDTH-1:0]  right_word,
   output logic [DATA_WIDTH-1:0]  entry_word
);
   import iira_pkg::*;

   localparam logic [CNT_W-1:0] MyIdx   = CNT_W'(IDX);
   localparam logic [CNT_W-1:0] NextIdx = CNT_W'(IDX + 1);

   logic [DATA_WIDTH-1:0] entry_ff;
   logic [DATA_WIDTH-1:0] entry_in;

   always_comb begin
      entry_in = entry_ff;
      case (cmd)
         CMD_WRITE: begin
            if (MyIdx == index) entry_in = word;
         end
         CMD_INSERT: begin
            if (MyIdx == index) begin
               entry_in = word;
            end else if (MyIdx > index) begin
               entry_in = left_word;
            end
         end
         CMD_REMOVE: begin
            if (MyIdx >= index && NextIdx < limit) begin
               entry_in = right_word;
            end else if (NextIdx == limit) begin
               entry_in = '0;
            end
         end
         CMD_CLEAR: entry_in = '0;
         default:   entry_in = entry_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff <= '0;
      end else begin
         entry_ff <= entry_in;
      end
   end

   assign entry_word = entry_ff;

endmodule

>>> rtl/core/indexed_insert_remove_array.sv
// Top level of the indexed insert/remove array: request decode, fill count and result register.
//
// Each request word is decoded in the cycle it is accepted and every cell of the row updates at
// once for a push, pop, insert, remove, get, set or clear; a new request can be accepted in every
// cycle unless a stalled result holds it. The result word appears in the cycle after its request
// is accepted and sits in a single output register; the next request is accepted in the same cycle
// that register is emptied or while it is empty. The read path is one select across all cells.
module indexed_insert_remove_array #(
   parameter int CAPACITY   = iira_pkg::DefaultCapacity,
   parameter int DATA_WIDTH = iira_pkg::DefaultDataWidth,
   parameter int CNT_W      = $clog2(CAPACITY + 1)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [2:0]            req_kind,
   input  logic [CNT_W-1:0]      req_position,
   input  logic [DATA_WIDTH-1:0] req_element_value,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [DATA_WIDTH-1:0] rsp_read_value,
   output logic [1:0]            rsp_status,
   output logic [CNT_W-1:0]      rsp_fill_count,
   output logic                  rsp_is_empty
);
   import iira_pkg::*;

   localparam logic [CNT_W-1:0] FullCount = CNT_W'(CAPACITY);

   logic [CNT_W-1:0]      count_ff;
   logic [CNT_W-1:0]      count_in;
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   logic [DATA_WIDTH-1:0] rsp_read_ff;
   logic [1:0]            rsp_status_ff;
   logic [CNT_W-1:0]      rsp_count_ff;
   logic                  req_fire;
   cell_cmd_type          cmd;
   logic [CNT_W-1:0]      cmd_index;
   status_type            status;
   logic                  rd_en;
   logic [CNT_W-1:0]      rd_idx;
   logic [DATA_WIDTH-1:0] rd_word;
   logic [DATA_WIDTH-1:0] words [CAPACITY];

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign req_fire  = req_valid && !req_stall;

   always_comb begin
      status    = ST_OK;
      cmd       = CMD_NONE;
      cmd_index = req_position;
      rd_en     = 1'b0;
      rd_idx    = req_position;
      count_in  = count_ff;
      unique case (kind_type'(req_kind))
         KIND_PUSH: begin
            if (count_ff == FullCount) begin
               status = ST_FULL;
            end else begin
               cmd       = CMD_WRITE;
               cmd_index = count_ff;
               count_in  = count_ff + 1'b1;
            end
         end
         KIND_POP: begin
            if (count_ff == '0) begin
               status = ST_EMPTY;
            end else begin
               rd_en    = 1'b1;
               rd_idx   = count_ff - 1'b1;
               count_in = count_ff - 1'b1;
            end
         end
         KIND_INSERT: begin
            if (req_position > count_ff) begin
               status = ST_RANGE;
            end else if (count_ff == FullCount) begin
               status = ST_FULL;
            end else begin
               cmd      = CMD_INSERT;
               count_in = count_ff + 1'b1;
            end
         end
         KIND_REMOVE: begin
            if (count_ff == '0) begin
               status = ST_EMPTY;
            end else if (req_position >= count_ff) begin
               status = ST_RANGE;
            end else begin
               cmd      = CMD_REMOVE;
               rd_en    = 1'b1;
               count_in = count_ff - 1'b1;
            end
         end
         KIND_GET: begin
            if (req_position >= count_ff) begin
               status = ST_RANGE;
            end else begin
               rd_en = 1'b1;
            end
         end
         KIND_SET: begin
            if (req_position >= count_ff) begin
               status = ST_RANGE;
            end else begin
               cmd = CMD_WRITE;
            end
         end
         KIND_CLEAR: begin
            cmd      = CMD_CLEAR;
            count_in = '0;
         end
         default: begin
            status = ST_OK;
         end
      endcase
      if (!req_fire) begin
         cmd      = CMD_NONE;
         count_in = count_ff;
      end
   end

   always_comb begin
      rd_word = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         if (rd_en && rd_idx == CNT_W'(i)) rd_word = words[i];
      end
   end

   for (genvar g = 0; g < CAPACITY; g++) begin : gen_cell
      logic [DATA_WIDTH-1:0] left_word;
      logic [DATA_WIDTH-1:0] right_word;
      if (g == 0) begin : gen_first
         assign left_word = '0;
      end else begin : gen_inner_left
         assign left_word = words[g-1];
      end
      if (g == CAPACITY - 1) begin : gen_last
         assign right_word = '0;
      end else begin : gen_inner_right
         assign right_word = words[g+1];
      end
      iira_cell #(
         .DATA_WIDTH (DATA_WIDTH),
         .CNT_W      (CNT_W),
         .IDX        (g)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .cmd        (cmd),
         .index      (cmd_index),
         .limit      (count_ff),
         .word       (req_element_value),
         .left_word  (left_word),
         .right_word (right_word),
         .entry_word (words[g])
      );
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_fire) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_read_ff   <= rd_word;
         rsp_status_ff <= status;
         rsp_count_ff  <= count_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_read_value = rsp_read_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_fill_count = rsp_count_ff;
   assign rsp_is_empty   = (rsp_count_ff == '0);

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FullCount)
      else $error("fill count exceeds capacity");

   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_kind == KIND_PUSH && count_ff != FullCount
      |=> count_ff == $past(count_ff) + 1'b1)
      else $error("accepted push did not grow the fill count");

   a_full_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_status_ff == ST_FULL |-> rsp_count_ff == FullCount)
      else $error("full status reported below capacity");

   a_rsp_count: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> rsp_valid_ff && rsp_count_ff == count_ff)
      else $error("result fill count does not match stored count");

endmodule
